// ----- design/sob_pkg.sv -----
`default_nettype none

package sob_pkg;

  localparam int unsigned PIX_W    = 16;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned DIM_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SUM_W    = PIX_W + 2;
  localparam int unsigned MIN_DIM  = 3;
  localparam int unsigned MAX_HEIGHT = 128;

  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [PIX_W-1:0]     mag_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_IMAGE_WIDTH    = 2'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT   = 2'd1;
  localparam cfg_idx_t REG_EDGE_THRESHOLD = 2'd2;

  localparam dim_t RST_IMAGE_WIDTH    = 8'd120;
  localparam dim_t RST_IMAGE_HEIGHT   = 8'd120;
  localparam pix_t RST_EDGE_THRESHOLD = 16'h8000;
  localparam mag_t MAG_MAX            = 16'hffff;

  // one column of the 3x3 window
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col3_t;

  // line buffer write request
  typedef struct packed {
    logic en;
    pix_t older;
    pix_t newer;
  } lb_wr_t;

endpackage

`default_nettype wire

// ----- design/sob_line_buf.sv -----
`default_nettype none

module sob_line_buf #(
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output logic [2*sob_pkg::PIX_W-1:0] rd_data,
  input  wire sob_pkg::lb_wr_t wr,
  input  wire logic [AW-1:0]   wr_addr
);

  logic [2*sob_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= {wr.older, wr.newer};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/sob_grad.sv -----
`default_nettype none

module sob_grad (
  input  wire sob_pkg::col3_t left,
  input  wire sob_pkg::pix_t  ctop,
  input  wire sob_pkg::pix_t  cbot,
  input  wire sob_pkg::col3_t right,
  input  wire sob_pkg::pix_t  threshold,
  output sob_pkg::mag_t       mag,
  output logic                edge_flag
);

  typedef logic [sob_pkg::SUM_W-1:0] sum_t;

  sum_t sum_r, sum_l, sum_b, sum_t_row, gx, gy;
  logic [sob_pkg::SUM_W:0] total;

  always_comb begin
    sum_r     = sum_t'(right.top) + sum_t'({right.mid, 1'b0}) + sum_t'(right.bot);
    sum_l     = sum_t'(left.top) + sum_t'({left.mid, 1'b0}) + sum_t'(left.bot);
    sum_b     = sum_t'(left.bot) + sum_t'({cbot, 1'b0}) + sum_t'(right.bot);
    sum_t_row = sum_t'(left.top) + sum_t'({ctop, 1'b0}) + sum_t'(right.top);
    gx = (sum_r >= sum_l) ? sum_r - sum_l : sum_l - sum_r;
    gy = (sum_b >= sum_t_row) ? sum_b - sum_t_row : sum_t_row - sum_b;
    total = {1'b0, gx} + {1'b0, gy};
    if (|total[sob_pkg::SUM_W:sob_pkg::PIX_W]) begin
      mag = sob_pkg::MAG_MAX;
    end else begin
      mag = total[sob_pkg::PIX_W-1:0];
    end
    edge_flag = (mag > threshold);
  end

endmodule

`default_nettype wire

// ----- design/sobel_edge_threshold_top.sv -----
`default_nettype none

// Channel  | Handshake              | Payload
// ---------+------------------------+-----------------------------------------------
// in       | in_valid / in_ready    | in_pixel
// out      | out_valid / out_ready  | out_edge_res, out_magnitude, out_row, out_col,
//          |                        | out_frame_last
// cfg      | cfg_wr_en              | cfg_index, cfg_wdata
//
// One pixel per cycle sustained while the output is not stalled; a pixel passes through
// the input register and its result into the result register. Line buffer read is
// registered at accept; line buffer write and window shift happen when the pixel moves into the result register.
// Border pixels produce no output transaction.
// Reset clears counters, window and valids and loads config defaults; line buffer contents stay unknown.
// A stalled output holds the result register; input stalls once the pipe is full.

module sobel_edge_threshold_top #(
  parameter int unsigned MAX_WIDTH = 128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [15:0]         in_pixel,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_edge_res,
  output logic [15:0]              out_magnitude,
  output logic [6:0]               out_row,
  output logic [6:0]               out_col,
  output logic                     out_frame_last,
  input  wire logic                cfg_wr_en,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_wdata
);

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned WCMP = (AW + 1 > 9) ? AW + 1 : 9;

  typedef logic [AW-1:0]   col_t;
  typedef logic [WCMP-1:0] wcmp_t;

  // config
  sob_pkg::dim_t width_r, height_r;
  sob_pkg::pix_t thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sob_pkg::RST_IMAGE_WIDTH;
      height_r <= sob_pkg::RST_IMAGE_HEIGHT;
      thresh_r <= sob_pkg::RST_EDGE_THRESHOLD;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sob_pkg::REG_IMAGE_WIDTH:    width_r  <= cfg_wdata[sob_pkg::DIM_W-1:0];
        sob_pkg::REG_IMAGE_HEIGHT:   height_r <= cfg_wdata[sob_pkg::DIM_W-1:0];
        sob_pkg::REG_EDGE_THRESHOLD: thresh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective last column and row
  wcmp_t         w_eff;
  sob_pkg::dim_t h_eff;
  col_t          last_col;
  sob_pkg::pos_t last_row;

  always_comb begin
    if (wcmp_t'(width_r) < wcmp_t'(sob_pkg::MIN_DIM)) begin
      w_eff = wcmp_t'(sob_pkg::MIN_DIM);
    end else if (wcmp_t'(width_r) > wcmp_t'(MAX_WIDTH)) begin
      w_eff = wcmp_t'(MAX_WIDTH);
    end else begin
      w_eff = wcmp_t'(width_r);
    end
    if (height_r < sob_pkg::dim_t'(sob_pkg::MIN_DIM)) begin
      h_eff = sob_pkg::dim_t'(sob_pkg::MIN_DIM);
    end else if (height_r > sob_pkg::dim_t'(sob_pkg::MAX_HEIGHT)) begin
      h_eff = sob_pkg::dim_t'(sob_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    last_col = col_t'(w_eff - wcmp_t'(1));
    last_row = sob_pkg::pos_t'(h_eff - sob_pkg::dim_t'(1));
  end

  // handshakes
  logic s1_valid_r, s1_adv, accept;

  assign s1_adv   = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  // raster counters
  col_t          col_r, col_nxt;
  sob_pkg::pos_t row_r, row_nxt;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_r >= last_col) begin
        col_nxt = '0;
        row_nxt = (row_r >= last_row) ? '0 : row_r + sob_pkg::pos_t'(1);
      end else begin
        col_nxt = col_r + col_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // input stage
  sob_pkg::pix_t s1_pix_r;
  col_t          s1_col_r;
  sob_pkg::pos_t s1_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r <= in_pixel;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
  end

  // line buffers
  logic [2*sob_pkg::PIX_W-1:0] lb_rd_data;
  sob_pkg::lb_wr_t             lb_wr;
  sob_pkg::col3_t              right;

  assign right.top = lb_rd_data[2*sob_pkg::PIX_W-1:sob_pkg::PIX_W];
  assign right.mid = lb_rd_data[sob_pkg::PIX_W-1:0];
  assign right.bot = s1_pix_r;

  assign lb_wr.en    = s1_adv;
  assign lb_wr.older = right.mid;
  assign lb_wr.newer = s1_pix_r;

  sob_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (lb_rd_data),
    .wr      (lb_wr),
    .wr_addr (s1_col_r)
  );

  // window: left column and center column
  sob_pkg::col3_t win_left_r, win_ctr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r <= '0;
      win_ctr_r  <= '0;
    end else if (s1_adv) begin
      win_left_r <= win_ctr_r;
      win_ctr_r  <= right;
    end
  end

  // gradient
  sob_pkg::mag_t mag;
  logic          edge_flag;

  sob_grad u_grad (
    .left      (win_left_r),
    .ctop      (win_ctr_r.top),
    .cbot      (win_ctr_r.bot),
    .right     (right),
    .threshold (thresh_r),
    .mag       (mag),
    .edge_flag (edge_flag)
  );

  logic interior, frame_last;
  col_t col_m1;

  always_comb begin
    interior = (s1_row_r >= sob_pkg::pos_t'(2)) && (s1_col_r >= col_t'(2)) &&
               (s1_row_r <= last_row) && (s1_col_r <= last_col);
    frame_last = (s1_row_r == last_row) && (s1_col_r == last_col);
    col_m1 = s1_col_r - col_t'(1);
  end

  // result register
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = interior;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  logic          out_edge_r, out_last_r;
  sob_pkg::mag_t out_mag_r;
  sob_pkg::pos_t out_row_r, out_col_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_edge_r <= edge_flag;
      out_mag_r  <= mag;
      out_row_r  <= s1_row_r - sob_pkg::pos_t'(1);
      out_col_r  <= sob_pkg::pos_t'(col_m1);
      out_last_r <= frame_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_res   = out_edge_r;
  assign out_magnitude  = out_mag_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_last = out_last_r;

endmodule

`default_nettype wire

// ----- verif/tb_sobel_edge_threshold_top.sv -----
`default_nettype none

module tb_sobel_edge_threshold_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W = 128;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RAND_PIXELS = 1500;
  localparam int unsigned SETTLE_CYCLES = 10;

  typedef struct {
    sob_pkg::pix_t pixel;
    int unsigned   gap;
  } pix_item_t;

  typedef struct {
    logic          edge_res;
    sob_pkg::mag_t magnitude;
    sob_pkg::pos_t row;
    sob_pkg::pos_t col;
    logic          last;
  } edge_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_pixel = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_edge_res;
  logic [15:0] out_magnitude;
  logic [6:0]  out_row;
  logic [6:0]  out_col;
  logic        out_frame_last;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  sobel_edge_threshold_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_edge_res  (out_edge_res),
    .out_magnitude (out_magnitude),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_frame_last(out_frame_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block: config, line buffers, window, raster position
  sob_pkg::dim_t cfg_width = sob_pkg::RST_IMAGE_WIDTH;
  sob_pkg::dim_t cfg_height = sob_pkg::RST_IMAGE_HEIGHT;
  sob_pkg::pix_t cfg_thr = sob_pkg::RST_EDGE_THRESHOLD;
  sob_pkg::pix_t lb_older [MAX_W];
  sob_pkg::pix_t lb_newer [MAX_W];
  bit            old_ok [MAX_W];
  bit            new_ok [MAX_W];
  sob_pkg::pix_t win [6] = '{default: '0};
  int unsigned   row_cnt = 0;
  int unsigned   col_cnt = 0;

  pix_item_t   pix_q [$];
  edge_rec_t   edge_q [$];
  edge_rec_t   want;
  int unsigned errs = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int          in_wait = -1;
  int          out_wait = -1;

  function automatic int unsigned fit_dim(input sob_pkg::dim_t v, input int unsigned hi);
    if (v < sob_pkg::MIN_DIM) return sob_pkg::MIN_DIM;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int unsigned draw_gap();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
  endfunction

  function automatic void predict_edge(input sob_pkg::pix_t px);
    int unsigned   w, h, r, c, sl, sr, st, sb, gx, gy, mag;
    sob_pkg::pix_t top, mid;
    edge_rec_t     e;
    w = fit_dim(cfg_width, MAX_W);
    h = fit_dim(cfg_height, sob_pkg::MAX_HEIGHT);
    r = row_cnt;
    c = col_cnt;
    top = '0;
    mid = '0;
    if (c < MAX_W) begin
      top = lb_older[c];
      mid = lb_newer[c];
    end
    if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1) begin
      sl = win[0] + 2 * win[1] + win[2];
      sr = top + 2 * mid + px;
      st = win[0] + 2 * win[3] + top;
      sb = win[2] + 2 * win[5] + px;
      gx = (sr >= sl) ? sr - sl : sl - sr;
      gy = (sb >= st) ? sb - st : st - sb;
      mag = gx + gy;
      if (mag > sob_pkg::MAG_MAX) mag = sob_pkg::MAG_MAX;
      e.edge_res = (mag > cfg_thr);
      e.magnitude = sob_pkg::mag_t'(mag);
      e.row = sob_pkg::pos_t'(r - 1);
      e.col = sob_pkg::pos_t'(c - 1);
      e.last = (r == h - 1 && c == w - 1);
      edge_q.push_back(e);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = px;
    if (c < MAX_W) begin
      lb_older[c] = mid;
      lb_newer[c] = px;
      old_ok[c] = new_ok[c];
      new_ok[c] = 1'b1;
    end
    if (c >= w - 1) begin
      col_cnt = 0;
      row_cnt = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      errs++;
    end
  endfunction

  task automatic write_reg(input sob_pkg::cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      sob_pkg::REG_IMAGE_WIDTH:    cfg_width = val[7:0];
      sob_pkg::REG_IMAGE_HEIGHT:   cfg_height = val[7:0];
      sob_pkg::REG_EDGE_THRESHOLD: cfg_thr = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pix_q.size() != 0 || in_valid || edge_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (in_wait < 0 && pix_q.size() != 0) in_wait = pix_q[0].gap;
      if (in_wait == 0) begin
        in_valid <= 1'b1;
        in_pixel <= pix_q[0].pixel;
        void'(pix_q.pop_front());
        in_wait = -1;
      end else begin
        in_valid <= 1'b0;
        if (in_wait > 0) in_wait--;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire || out_wait < 0) out_wait = calm ? 0 : draw_gap();
      if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: predict on pixel transaction, check on result transaction
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    out_fire <= out_valid && out_ready;
    if (rst_n && in_valid && in_ready) predict_edge(in_pixel);
    if (rst_n && out_valid && out_ready) begin
      if (edge_q.size() == 0) begin
        $error("unexpected result transaction: row %0d col %0d", out_row, out_col);
        errs++;
      end else begin
        want = edge_q.pop_front();
        check_field("out_edge_res", 16'(want.edge_res), 16'(out_edge_res));
        check_field("out_magnitude", want.magnitude, out_magnitude);
        check_field("out_row", 16'(want.row), 16'(out_row));
        check_field("out_col", 16'(want.col), 16'(out_col));
        check_field("out_frame_last", 16'(want.last), 16'(out_frame_last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sobel_edge_threshold_top: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned   n, w, h, r, c, wb, hb, base, mode, rand_items;
    bit            mid, ok;
    sob_pkg::pix_t p, thr;
    rand_items = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 3x3 frames: width below minimum, height zero, default threshold
    write_reg(sob_pkg::REG_IMAGE_WIDTH, 16'hff02);
    write_reg(sob_pkg::REG_IMAGE_HEIGHT, 16'h0000);
    for (int i = 0; i < 9; i++) pix_q.push_back('{pixel: (i % 3 == 0) ? 16'hffff : 16'h0, gap: 0});
    wait_idle();
    write_reg(sob_pkg::REG_EDGE_THRESHOLD, 16'hffff);
    for (int i = 0; i < 9; i++) pix_q.push_back('{pixel: (i % 3 == 0) ? 16'hffff : 16'h0, gap: 0});
    wait_idle();
    // gentle ramp, magnitude equals threshold
    write_reg(sob_pkg::REG_EDGE_THRESHOLD, 16'h0008);
    for (int i = 0; i < 9; i++) pix_q.push_back('{pixel: sob_pkg::pix_t'(i % 3), gap: 0});

    while (rand_items < RAND_PIXELS) begin
      wait_idle();
      calm = ($urandom_range(0, 5) == 0);
      mid = (row_cnt != 0 || col_cnt != 0);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: wb = $urandom_range(0, 3);
          1: wb = $urandom_range(129, 255);
          2: wb = 128;
          3: wb = $urandom_range(21, 127);
          default: wb = $urandom_range(3, 20);
        endcase
        // growing mid frame must only reach line buffer entries already filled
        ok = 1'b1;
        if (mid) begin
          for (int i = 0; i < fit_dim(sob_pkg::dim_t'(wb), MAX_W); i++) begin
            if (!(old_ok[i] && new_ok[i])) ok = 1'b0;
          end
        end
        if (ok) write_reg(sob_pkg::REG_IMAGE_WIDTH, {8'($urandom), sob_pkg::dim_t'(wb)});
      end
      w = fit_dim(cfg_width, MAX_W);
      if (w > 24 || $urandom_range(0, 3) != 0) begin
        if (w > 24) begin
          hb = $urandom_range(0, 5);
        end else begin
          case ($urandom_range(0, 5))
            0: hb = $urandom_range(0, 2);
            1: hb = (w <= 4) ? $urandom_range(100, 255) : $urandom_range(3, 10);
            default: hb = $urandom_range(3, 10);
          endcase
        end
        write_reg(sob_pkg::REG_IMAGE_HEIGHT, {8'($urandom), sob_pkg::dim_t'(hb)});
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0: thr = 16'h0000;
          1: thr = 16'hffff;
          2: thr = sob_pkg::pix_t'($urandom_range(0, 1023));
          default: thr = sob_pkg::pix_t'($urandom);
        endcase
        write_reg(sob_pkg::REG_EDGE_THRESHOLD, thr);
      end

      w = fit_dim(cfg_width, MAX_W);
      h = fit_dim(cfg_height, sob_pkg::MAX_HEIGHT);
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, w * h);
      end else begin
        // run to the end of the current frame
        n = 0;
        r = row_cnt;
        c = col_cnt;
        do begin
          n++;
          if (c >= w - 1) begin
            c = 0;
            r = (r >= h - 1) ? 0 : r + 1;
          end else begin
            c++;
          end
        end while (r != 0 || c != 0);
      end
      mode = $urandom_range(0, 3);
      base = $urandom_range(0, 16'hffc0);
      repeat (n) begin
        case (mode)
          2: p = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
          3: p = sob_pkg::pix_t'(base + $urandom_range(0, 63));
          default: p = sob_pkg::pix_t'($urandom);
        endcase
        pix_q.push_back('{pixel: p, gap: calm ? 0 : draw_gap()});
      end
      rand_items += n;
    end

    wait_idle();
    if (errs == 0) begin
      $display("tb_sobel_edge_threshold_top: PASS");
    end else begin
      $display("tb_sobel_edge_threshold_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/sob_pkg.sv
design/sob_line_buf.sv
design/sob_grad.sv
design/sobel_edge_threshold_top.sv
verif/tb_sobel_edge_threshold_top.sv
